// ===== rtl/bcf_pkg.sv =====
package bcf_pkg;

    localparam int SECTIONS    = 3;
    localparam int SAMPLE_BITS = 12;

    localparam int TAPS        = 5;
    localparam int TABLE_SIZE  = SECTIONS * TAPS;
    localparam int Q_BITS      = 32;
    localparam int Q_FRAC      = 24;
    localparam int IO_SHIFT    = 25 - SAMPLE_BITS;
    localparam int CA_BITS     = $clog2(TABLE_SIZE);
    localparam int SEC_BITS    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int V_BITS      = Q_BITS - IO_SHIFT + 1;
    localparam int DESIGN_SIZE = 15;

    typedef logic signed [Q_BITS-1:0] t_q;
    typedef t_q t_coef_tbl [TABLE_SIZE];

    // per-section delay line: x[n-1], x[n-2], y[n-1], y[n-2]
    typedef struct packed {
        t_q x1;
        t_q x2;
        t_q y1;
        t_q y2;
    } t_row;

    typedef struct packed {
        logic vld;
        logic first;
        logic sub;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        TAP_B0,
        TAP_B1,
        TAP_B2,
        TAP_A1,
        TAP_A2
    } t_tap;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    localparam t_q Q_ONE = t_q'(1) <<< Q_FRAC;

    localparam t_q DESIGN_TABLE [DESIGN_SIZE] = '{
        32'sd47, 32'sd94, 32'sd47, -32'sd32751155, 32'sd16305830,
        32'sd16777216, 32'sd0, -32'sd16777216, -32'sd32899393, 32'sd16519582,
        32'sd16777216, -32'sd33554432, 32'sd16777216, -32'sd33056371, 32'sd16560225
    };

    // sections past the designed ones pass the signal through
    function automatic t_coef_tbl init_coefs();
        t_coef_tbl tbl;
        int        t;
        t = 0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (i < DESIGN_SIZE) begin
                tbl[i] = DESIGN_TABLE[i];
            end else begin
                tbl[i] = (t == 0) ? Q_ONE : '0;
            end
            t = (t == TAPS - 1) ? 0 : t + 1;
        end
        return tbl;
    endfunction

    localparam t_coef_tbl COEF_INIT = init_coefs();

    // offset binary sample to q8.24
    function automatic t_q to_q(input logic [SAMPLE_BITS-1:0] s);
        logic signed [SAMPLE_BITS-1:0] c;
        c = {~s[SAMPLE_BITS-1], s[SAMPLE_BITS-2:0]};
        return t_q'(c) <<< IO_SHIFT;
    endfunction

    // q8.24 back to offset binary, floor shift then clamp
    function automatic logic [SAMPLE_BITS-1:0] to_dac(input t_q y);
        logic [V_BITS-1:0] v;
        logic [SAMPLE_BITS-1:0] r;
        v = {y[Q_BITS-1], y[Q_BITS-1:IO_SHIFT]} + V_BITS'(1 << (SAMPLE_BITS - 1));
        if (v[V_BITS-1]) begin
            r = '0;
        end else if (|v[V_BITS-2:SAMPLE_BITS]) begin
            r = '1;
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/biquad_cascade_filter.sv =====
// a sample beat gives its result once it has passed through every section in turn
// no new sample is accepted (o_in_stall) until that result is handed on; all sections
//   share the one multiply-accumulate and the coefficient memory read port
// a coefficient beat writes the coefficient memory and gives no result
// reset (synchronous, active low) restores the design coefficients and clears
//   all delay state through per-entry valid bits, with no clearing pass
module biquad_cascade_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [11:0] i_adc_sample,
    input  logic [3:0]  i_coef_index,
    input  logic signed [31:0] i_coef_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_out_sample
);
    import bcf_pkg::*;

    localparam int CYC_BITS = 3;
    localparam logic [CYC_BITS-1:0] CYC_LAST = '1;

    t_state                r_state, n_state;
    logic [SEC_BITS-1:0]   r_sec, n_sec;
    logic [CYC_BITS-1:0]   r_cyc, n_cyc;
    t_q                    r_x, n_x;
    logic                  r_s1_vld, n_s1_vld;
    t_tap                  r_s1_tap, n_s1_tap;
    logic                  r_out_vld, n_out_vld;
    logic [SAMPLE_BITS-1:0] r_dac, n_dac;

    logic                  in_acc;
    logic                  out_free;
    logic                  issue;
    logic                  coef_wr;
    logic [CA_BITS-1:0]    coef_rd_addr;
    t_q                    coef_rd_data;
    logic                  row_rd;
    logic                  row_wr;
    t_row                  row_rd_data;
    t_row                  row_wr_data;
    t_mac_ctl              mac_ctl;
    t_q                    operand;
    t_q                    acc;

    assign o_in_stall   = (r_state != ST_IDLE);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_vld || !i_out_stall;
    assign coef_wr      = in_acc && i_mode &&
                          (32'(i_coef_index) < 32'(TABLE_SIZE));
    assign o_out_valid  = r_out_vld;
    assign o_out_sample = r_dac;

    bcf_coef_mem u_coef_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (coef_wr),
        .i_wr_addr (CA_BITS'(i_coef_index)),
        .i_wr_data (i_coef_value),
        .i_rd_en   (issue),
        .i_rd_addr (coef_rd_addr),
        .o_rd_data (coef_rd_data)
    );

    bcf_state_mem u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (row_wr),
        .i_wr_addr (r_sec),
        .i_wr_data (row_wr_data),
        .i_rd_en   (row_rd),
        .i_rd_addr (r_sec),
        .o_rd_data (row_rd_data)
    );

    bcf_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_coef    (coef_rd_data),
        .i_operand (operand),
        .o_acc     (acc)
    );

    // operand of the tap whose coefficient arrives this cycle
    always_comb begin
        case (r_s1_tap)
            TAP_B0:  operand = r_x;
            TAP_B1:  operand = row_rd_data.x1;
            TAP_B2:  operand = row_rd_data.x2;
            TAP_A1:  operand = row_rd_data.y1;
            TAP_A2:  operand = row_rd_data.y2;
            default: operand = r_x;
        endcase
        mac_ctl.vld   = r_s1_vld;
        mac_ctl.first = (r_s1_tap == TAP_B0);
        mac_ctl.sub   = (r_s1_tap == TAP_A1) || (r_s1_tap == TAP_A2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sec     <= '0;
            r_cyc     <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_tap  <= TAP_B0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sec     <= n_sec;
            r_cyc     <= n_cyc;
            r_s1_vld  <= n_s1_vld;
            r_s1_tap  <= n_s1_tap;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_dac <= n_dac;
    end

    // per section: taps issue at r_cyc 0..4, the accumulator settles by r_cyc 7,
    // and r_cyc 7 writes the delay row back and hands y to the next section
    always_comb begin
        n_state      = r_state;
        n_sec        = r_sec;
        n_cyc        = r_cyc;
        n_x          = r_x;
        n_dac        = r_dac;
        n_out_vld    = out_free ? 1'b0 : r_out_vld;
        issue        = 1'b0;
        row_rd       = 1'b0;
        row_wr       = 1'b0;
        coef_rd_addr = CA_BITS'(r_sec) * CA_BITS'(TAPS) + CA_BITS'(r_cyc);
        row_wr_data  = '{x1: r_x, x2: row_rd_data.x1, y1: acc, y2: row_rd_data.y1};
        n_s1_vld     = 1'b0;
        n_s1_tap     = t_tap'(r_cyc);
        case (r_state)
            ST_IDLE: begin
                if (in_acc && !i_mode) begin
                    n_x     = to_q(i_adc_sample);
                    n_sec   = '0;
                    n_cyc   = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                issue    = (r_cyc < CYC_BITS'(TAPS));
                row_rd   = (r_cyc == '0);
                n_s1_vld = issue;
                n_cyc    = r_cyc + 1'b1;
                if (r_cyc == CYC_LAST) begin
                    row_wr = 1'b1;
                    n_x    = acc;
                    if (r_sec == SEC_BITS'(SECTIONS - 1)) begin
                        n_state = ST_OUT;
                    end else begin
                        n_sec = r_sec + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_dac     = to_dac(r_x);
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_mode) |=> (r_state == ST_RUN && r_sec == '0 && r_cyc == '0))
        else $error("sample beat did not start the section sweep");

    a_mac_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == ST_RUN && r_cyc <= CYC_BITS'(TAPS)))
        else $error("multiply issued outside a section pass");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT && r_state == ST_IDLE))
        else $error("result beat raised without finishing the cascade");

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_sec <= SEC_BITS'(SECTIONS - 1)))
        else $error("section counter out of range");

endmodule

// ===== rtl/bcf_coef_mem.sv =====
module bcf_coef_mem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [bcf_pkg::CA_BITS-1:0] i_wr_addr,
    input  bcf_pkg::t_q           i_wr_data,
    input  logic                  i_rd_en,
    input  logic [bcf_pkg::CA_BITS-1:0] i_rd_addr,
    output bcf_pkg::t_q           o_rd_data
);
    import bcf_pkg::*;

    t_q                    r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_vld;
    t_q                    r_rd_data;

    // entries never written read as the design coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : COEF_INIT[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bcf_state_mem.sv =====
module bcf_state_mem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [bcf_pkg::SEC_BITS-1:0] i_wr_addr,
    input  bcf_pkg::t_row         i_wr_data,
    input  logic                  i_rd_en,
    input  logic [bcf_pkg::SEC_BITS-1:0] i_rd_addr,
    output bcf_pkg::t_row         o_rd_data
);
    import bcf_pkg::*;

    t_row                r_mem [SECTIONS];
    logic [SECTIONS-1:0] r_vld;
    t_row                r_rd_data;

    // a row not yet written back reads as cleared delays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bcf_mac.sv =====
module bcf_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcf_pkg::t_mac_ctl i_ctl,
    input  bcf_pkg::t_q       i_coef,
    input  bcf_pkg::t_q       i_operand,
    output bcf_pkg::t_q       o_acc
);
    import bcf_pkg::*;

    logic signed [2*Q_BITS-1:0] r_prod;
    t_mac_ctl                   r_ctl;
    t_q                         r_acc;
    t_q                         n_acc;
    t_q                         p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= (2*Q_BITS)'(i_coef) * (2*Q_BITS)'(i_operand);
        if (r_ctl.vld) begin
            r_acc <= n_acc;
        end
    end

    // product rescaled to q8.24, sums wrap at 32 bits
    always_comb begin
        p     = t_q'(r_prod[Q_FRAC+Q_BITS-1:Q_FRAC]);
        n_acc = (r_ctl.first ? t_q'(0) : r_acc) + (r_ctl.sub ? -p : p);
    end

    assign o_acc = r_acc;

endmodule
